// File: rtl/tre_pkg.sv
package tre_pkg;

   localparam int MAX_PACKET   = 128;
   localparam int RESULT_LANES = 4;
   localparam int LANE_W       = $clog2(RESULT_LANES);
   localparam int PIXEL_W      = 32;
   localparam int COUNT_W      = 8;
   localparam int PBYTES_W     = 3;
   localparam int PCOUNT_W     = 3;
   localparam int HEADER_W     = 8;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 3;
   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [HEADER_W-1:0]    RUN_HDR_BASE = 8'h80;
   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_ENABLE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES = 1'd1;
   localparam logic [PBYTES_W-1:0]    PIXEL_BYTES_RESET = 3'd3;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_RUN,
      CMD_ENDROW
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [PIXEL_W-1:0]   pixel;
      logic [COUNT_W-1:0]   count;
      logic                 is_final;
   } cmd_type;

   typedef struct packed {
      logic                                   has_header;
      logic [HEADER_W-1:0]                    header_byte;
      logic [PCOUNT_W-1:0]                    pixel_count;
      logic [RESULT_LANES-1:0][PIXEL_W-1:0]   pixels;
      logic                                   final_item;
   } rsp_type;

   function automatic logic [PIXEL_W-1:0] byte_mask(input logic [PBYTES_W-1:0] pb);
      logic [PIXEL_W-1:0] m;
      case (pb) inside
         3'd0, 3'd1: m = 32'h0000_00FF;
         3'd2:       m = 32'h0000_FFFF;
         3'd3:       m = 32'h00FF_FFFF;
         default:    m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// File: rtl/tre_if.sv
interface tre_req_if;
   logic                         valid;
   logic                         ready;
   logic [tre_pkg::PIXEL_W-1:0]  pixel_value;
   logic                         row_end;

   modport source (output valid, output pixel_value, output row_end, input ready);
   modport sink   (input valid, input pixel_value, input row_end, output ready);
endinterface

interface tre_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          has_header;
   logic [tre_pkg::HEADER_W-1:0]  header_byte;
   logic [tre_pkg::PCOUNT_W-1:0]  pixel_count;
   logic [tre_pkg::PIXEL_W-1:0]   pixel_a;
   logic [tre_pkg::PIXEL_W-1:0]   pixel_b;
   logic [tre_pkg::PIXEL_W-1:0]   pixel_c;
   logic [tre_pkg::PIXEL_W-1:0]   pixel_d;
   logic                          final_item;

   modport source (output valid, output has_header, output header_byte, output pixel_count,
                   output pixel_a, output pixel_b, output pixel_c, output pixel_d,
                   output final_item, input ready);
   modport sink   (input valid, input has_header, input header_byte, input pixel_count,
                   input pixel_a, input pixel_b, input pixel_c, input pixel_d,
                   input final_item, output ready);
endinterface

// File: rtl/tga_rle_row_encoder.sv
// channel   dir  payload                                            handshake
// req_chan  in   pixel_value[31:0], row_end                         valid/ready
// rsp_chan  out  has_header, header_byte[7:0], pixel_count[2:0],    valid/ready
//                pixel_a..pixel_d[31:0], final_item
// csr       in   csr_write_enable, csr_index[0], csr_write_data[2:0]  write only
//
// a pixel's up to three commands move into the command queue one per cycle while the
// queue has room, and the input takes no new pixel until all of them have moved in
// literal packets leave beat by beat, each a registered bank read, then the beat;
// a repeat or pass-through beat in the back end is: take command, then beat
// synchronous reset clears runs, counts, queue and output; rle on, 3 bytes per pixel
// either side stalls independently through the command queue and the output register
module tga_rle_row_encoder #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET
) (
   input  logic                              clock,
   input  logic                              reset,
   tre_req_if.sink                           req_chan,
   tre_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tre_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tre_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                          rle_enable_ff, rle_enable_in;
   logic [tre_pkg::PBYTES_W-1:0]  pixel_bytes_ff, pixel_bytes_in;

   logic                          f_cmd_valid, f_cmd_ready;
   tre_pkg::cmd_type              f_cmd;
   logic                          b_cmd_valid, b_cmd_ready;
   tre_pkg::cmd_type              b_cmd;
   tre_pkg::rsp_type              rsp;

   always_comb begin
      rle_enable_in  = rle_enable_ff;
      pixel_bytes_in = pixel_bytes_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tre_pkg::CSR_RLE_ENABLE:  rle_enable_in  = csr_write_data[0];
            tre_pkg::CSR_PIXEL_BYTES: pixel_bytes_in = csr_write_data[tre_pkg::PBYTES_W-1:0];
            default: begin
               rle_enable_in = rle_enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_enable_ff  <= 1'b1;
         pixel_bytes_ff <= tre_pkg::PIXEL_BYTES_RESET;
      end else begin
         rle_enable_ff  <= rle_enable_in;
         pixel_bytes_ff <= pixel_bytes_in;
      end
   end

   tre_front #(.MAX_PACKET(MAX_PACKET)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_pixel   (req_chan.pixel_value),
      .req_row_end (req_chan.row_end),
      .rle_enable  (rle_enable_ff),
      .pixel_bytes (pixel_bytes_ff),
      .cmd_valid   (f_cmd_valid),
      .cmd_ready   (f_cmd_ready),
      .cmd         (f_cmd)
   );

   tre_cmd_fifo #(.DEPTH(tre_pkg::CMD_FIFO_DEPTH)) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_cmd_valid),
      .push_ready (f_cmd_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (b_cmd_valid),
      .pop_ready  (b_cmd_ready),
      .pop_cmd    (b_cmd)
   );

   tre_back #(.MAX_PACKET(MAX_PACKET)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_cmd_valid),
      .cmd_ready (b_cmd_ready),
      .cmd       (b_cmd),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp       (rsp)
   );

   assign rsp_chan.has_header  = rsp.has_header;
   assign rsp_chan.header_byte = rsp.header_byte;
   assign rsp_chan.pixel_count = rsp.pixel_count;
   assign rsp_chan.pixel_a     = rsp.pixels[0];
   assign rsp_chan.pixel_b     = rsp.pixels[1];
   assign rsp_chan.pixel_c     = rsp.pixels[2];
   assign rsp_chan.pixel_d     = rsp.pixels[3];
   assign rsp_chan.final_item  = rsp.final_item;

endmodule

// File: rtl/tre_front.sv
module tre_front #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tre_pkg::PIXEL_W-1:0]     req_pixel,
   input  logic                            req_row_end,
   input  logic                            rle_enable,
   input  logic [tre_pkg::PBYTES_W-1:0]    pixel_bytes,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output tre_pkg::cmd_type                cmd
);

   localparam int CW = tre_pkg::COUNT_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);

   logic [tre_pkg::PIXEL_W-1:0] run_pixel_ff, run_pixel_in;
   logic [CW-1:0]               run_count_ff, run_count_in;
   logic [CW-1:0]               lit_count_ff, lit_count_in;
   tre_pkg::cmd_type            pend_ff [3];
   tre_pkg::cmd_type            pend_in [3];
   logic [2:0]                  pend_valid_ff, pend_valid_in;

   logic [tre_pkg::PIXEL_W-1:0] p;
   logic                        same, close_old, old_big, out1, out2, out3;
   logic [CW-1:0]               lit1, lit2, rc;
   logic                        accept;

   assign req_ready = (pend_valid_ff == 3'b000);
   assign accept    = req_valid && req_ready;

   // walk the open run and literal count through this pixel's closes
   always_comb begin
      p         = req_pixel & tre_pkg::byte_mask(pixel_bytes);
      same      = (run_count_ff != '0) && (p == run_pixel_ff) && (run_count_ff < MAX_C);
      close_old = !same && (run_count_ff != '0);
      old_big   = (run_count_ff >= CW'(2));
      out1      = close_old && (old_big || (lit_count_ff + 1'b1 == MAX_C));
      if (!close_old) begin
         lit1 = lit_count_ff;
      end else if (out1) begin
         lit1 = '0;
      end else begin
         lit1 = lit_count_ff + 1'b1;
      end
      rc   = same ? run_count_ff + 1'b1 : CW'(1);
      out2 = (rc >= CW'(2)) || (lit1 + 1'b1 == MAX_C);
      lit2 = out2 ? '0 : lit1 + 1'b1;
      out3 = (lit2 != '0);
   end

   always_comb begin
      run_pixel_in  = run_pixel_ff;
      run_count_in  = run_count_ff;
      lit_count_in  = lit_count_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cmd_valid     = (pend_valid_ff != 3'b000);
      cmd           = pend_ff[0];

      if (pend_valid_ff[0]) begin
         cmd = pend_ff[0];
         if (cmd_ready) pend_valid_in[0] = 1'b0;
      end else if (pend_valid_ff[1]) begin
         cmd = pend_ff[1];
         if (cmd_ready) pend_valid_in[1] = 1'b0;
      end else begin
         cmd = pend_ff[2];
         if (cmd_ready) pend_valid_in[2] = 1'b0;
      end

      if (accept) begin
         if (!rle_enable) begin
            pend_in[0]    = '{op: tre_pkg::CMD_PASS, pixel: p, count: CW'(1), is_final: 1'b1};
            pend_valid_in = 3'b001;
         end else begin
            pend_in[0] = '{op: tre_pkg::CMD_RUN, pixel: run_pixel_ff, count: run_count_ff,
                           is_final: out1 && !(req_row_end && (out2 || out3))};
            pend_in[1] = '{op: tre_pkg::CMD_RUN, pixel: p, count: rc,
                           is_final: out2 && !out3};
            pend_in[2] = '{op: tre_pkg::CMD_ENDROW, pixel: p, count: lit2,
                           is_final: 1'b1};
            pend_valid_in = {req_row_end && out3, req_row_end, close_old};
            run_pixel_in  = p;
            run_count_in  = req_row_end ? '0 : rc;
            lit_count_in  = req_row_end ? '0 : lit1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pixel_ff  <= '0;
         run_count_ff  <= '0;
         lit_count_ff  <= '0;
         pend_valid_ff <= '0;
      end else begin
         run_pixel_ff  <= run_pixel_in;
         run_count_ff  <= run_count_in;
         lit_count_ff  <= lit_count_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

endmodule

// File: rtl/tre_cmd_fifo.sv
module tre_cmd_fifo #(
   parameter int DEPTH = tre_pkg::CMD_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tre_pkg::cmd_type   push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tre_pkg::cmd_type   pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tre_pkg::cmd_type  q_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) q_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// File: rtl/tre_back.sv
module tre_back #(
   parameter int MAX_PACKET = tre_pkg::MAX_PACKET
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  tre_pkg::cmd_type   cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tre_pkg::rsp_type   rsp
);

   localparam int CW         = tre_pkg::COUNT_W;
   localparam int LANES      = tre_pkg::RESULT_LANES;
   localparam int LW         = tre_pkg::LANE_W;
   localparam int PW         = tre_pkg::PIXEL_W;
   localparam int BANK_DEPTH = (MAX_PACKET + LANES - 1) / LANES;
   localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_EMIT,
      B_SINGLE
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      lit_count_ff, lit_count_in;
   logic [CW-1:0]      fl_total_ff, fl_total_in;
   logic [ROW_W-1:0]   fl_row_ff, fl_row_in;
   logic               fl_final_ff, fl_final_in;
   logic               after_single_ff, after_single_in;
   tre_pkg::rsp_type   single_ff, single_in;
   logic               out_valid_ff, out_valid_in;
   tre_pkg::rsp_type   out_ff, out_in;

   logic [PW-1:0]      lit_mem [LANES][BANK_DEPTH];
   logic [PW-1:0]      rd_data_ff [LANES];
   logic               wr_en, rd_en;
   logic [LW-1:0]      wr_lane;
   logic [ROW_W-1:0]   wr_row;

   logic               slot_free;
   logic [CW-1:0]      row_base, rem;
   logic               last_row;
   logic [tre_pkg::PCOUNT_W-1:0] lit_cnt;
   tre_pkg::rsp_type   lit_item;

   assign cmd_ready = (state_ff == B_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign wr_lane   = lit_count_ff[LW-1:0];
   assign wr_row    = ROW_W'(lit_count_ff >> LW);

   // one literal beat from the registered bank row
   always_comb begin
      row_base = CW'(fl_row_ff) << LW;
      rem      = fl_total_ff - row_base;
      last_row = (rem <= CW'(LANES));
      lit_cnt  = last_row ? rem[tre_pkg::PCOUNT_W-1:0] : tre_pkg::PCOUNT_W'(LANES);
      lit_item.has_header  = (fl_row_ff == '0);
      lit_item.header_byte = (fl_row_ff == '0) ? tre_pkg::HEADER_W'(fl_total_ff - 1'b1) : '0;
      lit_item.pixel_count = lit_cnt;
      for (int l = 0; l < LANES; l++) begin
         lit_item.pixels[l] = (tre_pkg::PCOUNT_W'(l) < lit_cnt) ? rd_data_ff[l] : '0;
      end
      lit_item.final_item = fl_final_ff && !after_single_ff && last_row;
   end

   always_comb begin
      state_in        = state_ff;
      lit_count_in    = lit_count_ff;
      fl_total_in     = fl_total_ff;
      fl_row_in       = fl_row_ff;
      fl_final_in     = fl_final_ff;
      after_single_in = after_single_ff;
      single_in       = single_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_in          = out_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               single_in             = '0;
               single_in.pixel_count = tre_pkg::PCOUNT_W'(1);
               single_in.pixels[0]   = cmd.pixel;
               single_in.final_item  = cmd.is_final;
               fl_row_in             = '0;
               case (cmd.op)
                  tre_pkg::CMD_PASS: begin
                     state_in = B_SINGLE;
                  end
                  tre_pkg::CMD_RUN: begin
                     if (cmd.count >= CW'(2)) begin
                        single_in.has_header  = 1'b1;
                        single_in.header_byte = tre_pkg::RUN_HDR_BASE + cmd.count - 1'b1;
                        if (lit_count_ff != '0) begin
                           fl_total_in     = lit_count_ff;
                           fl_final_in     = 1'b0;
                           after_single_in = 1'b1;
                           lit_count_in    = '0;
                           state_in        = B_READ;
                        end else begin
                           state_in = B_SINGLE;
                        end
                     end else begin
                        wr_en = 1'b1;
                        if (lit_count_ff + 1'b1 == MAX_C) begin
                           fl_total_in     = MAX_C;
                           fl_final_in     = cmd.is_final;
                           after_single_in = 1'b0;
                           lit_count_in    = '0;
                           state_in        = B_READ;
                        end else begin
                           lit_count_in = lit_count_ff + 1'b1;
                        end
                     end
                  end
                  tre_pkg::CMD_ENDROW: begin
                     if (lit_count_ff != '0) begin
                        fl_total_in     = lit_count_ff;
                        fl_final_in     = cmd.is_final;
                        after_single_in = 1'b0;
                        lit_count_in    = '0;
                        state_in        = B_READ;
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = lit_item;
               if (last_row) begin
                  state_in = after_single_ff ? B_SINGLE : B_IDLE;
               end else begin
                  fl_row_in = fl_row_ff + 1'b1;
                  state_in  = B_READ;
               end
            end
         end
         B_SINGLE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = single_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         lit_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lit_count_ff <= lit_count_in;
         out_valid_ff <= out_valid_in;
      end
      fl_total_ff     <= fl_total_in;
      fl_row_ff       <= fl_row_in;
      fl_final_ff     <= fl_final_in;
      after_single_ff <= after_single_in;
      single_ff       <= single_in;
      out_ff          <= out_in;
   end

   // literal buffer, one bank per result lane
   always_ff @(posedge clock) begin
      if (wr_en) lit_mem[wr_lane][wr_row] <= cmd.pixel;
      if (rd_en) begin
         for (int l = 0; l < LANES; l++) begin
            rd_data_ff[l] <= lit_mem[l][fl_row_ff];
         end
      end
   end

endmodule

// File: rtl/tre_checker.sv
module tre_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             has_header,
   input logic [tre_pkg::HEADER_W-1:0]     header_byte,
   input logic [tre_pkg::PCOUNT_W-1:0]     pixel_count,
   input logic [tre_pkg::PIXEL_W-1:0]      pixel_d,
   input logic                             final_item
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(header_byte) &&
         $stable(pixel_count) && $stable(final_item) && $stable(has_header))
      else $error("rsp beat changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pixel_count != 3'd0) && (pixel_count <= 3'd4) &&
         ((pixel_count == 3'd4) || (pixel_d == '0)))
      else $error("bad pixel count or unused slot not cleared");

   // repeat packet: one pixel, run of two or more
   a_repeat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_header && header_byte[7] |->
         (pixel_count == 3'd1) && (header_byte != tre_pkg::RUN_HDR_BASE))
      else $error("malformed repeat packet");

   a_no_header_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_header |-> header_byte == '0)
      else $error("header byte set on continuation beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind tga_rle_row_encoder tre_checker u_tre_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .has_header  (rsp_chan.has_header),
   .header_byte (rsp_chan.header_byte),
   .pixel_count (rsp_chan.pixel_count),
   .pixel_d     (rsp_chan.pixel_d),
   .final_item  (rsp_chan.final_item)
);
